>>> hw/rtl/pufp_pkg.sv
`default_nettype none
package pufp_pkg;

	// Pixel format codes
	localparam logic [3:0] FMT_R8        = 4'd0;
	localparam logic [3:0] FMT_RG8       = 4'd1;
	localparam logic [3:0] FMT_RGB8      = 4'd2;
	localparam logic [3:0] FMT_RGBA8     = 4'd3;
	localparam logic [3:0] FMT_RGBA8SRGB = 4'd4;
	localparam logic [3:0] FMT_BGRA8     = 4'd5;
	localparam logic [3:0] FMT_BGRA8SRGB = 4'd6;
	localparam logic [3:0] FMT_R16F      = 4'd7;
	localparam logic [3:0] FMT_RG16F     = 4'd8;
	localparam logic [3:0] FMT_RGBA16F   = 4'd9;
	localparam logic [3:0] FMT_R32F      = 4'd10;
	localparam logic [3:0] FMT_RG32F     = 4'd11;
	localparam logic [3:0] FMT_RGBA32F   = 4'd12;

	localparam logic [3:0]  FMT_RESET = FMT_RGBA8;
	localparam logic [31:0] F32_ONE   = 32'h3f80_0000;

	typedef struct packed {
		logic [31:0] pixel_word0;
		logic [31:0] pixel_word1;
		logic [31:0] pixel_word2;
		logic [31:0] pixel_word3;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] red_bits;
		logic [31:0] green_bits;
		logic [31:0] blue_bits;
		logic [31:0] alpha_bits;
		logic        format_ok;
	} rgba_out_t;

	// Nearest float32 to n/255. For n in 1..254 the exponent is set by the
	// leading bit of n; the mantissa is n shifted up, divided by 255 and rounded.
	// The top module folds it into a 256-entry constant table.
	function automatic logic [31:0] unorm8_f32(input logic [7:0] n);
		logic [31:0] res;
		logic [5:0]  s;
		logic [39:0] num;
		logic [39:0] q;
		logic [39:0] r;
		logic [7:0]  e;
		res = 32'd0;
		s = 6'd31;
		num = 40'd0;
		q = 40'd0;
		r = 40'd0;
		e = 8'd0;
		if (n == 8'd255) begin
			res = F32_ONE;
		end else if (n != 8'd0) begin
			// leading bit position sets the shift
			for (int i = 7; i >= 0; i--) begin
				if (n[i] && s == 6'd31) s = 6'(31 - i);
			end
			if (s > 6'd24) begin
				num = {32'd0, n} << s;
				q = num / 40'd255;
				if (q < 40'h80_0000) s = s + 6'd1;
			end
			num = {32'd0, n} << s;
			q = num / 40'd255;
			r = num % 40'd255;
			if (r > 40'd127) q = q + 40'd1;
			e = 8'(150 - 32'(s));
			if (q >= 40'h100_0000) begin
				q = q >> 1;
				e = e + 8'd1;
			end
			res = {1'b0, e, q[22:0]};
		end
		return res;
	endfunction

	// Exact half to float32 widening
	function automatic logic [31:0] half_f32(input logic [15:0] h);
		logic [9:0]  man;
		logic [7:0]  e;
		logic [31:0] res;
		man = h[9:0];
		e = 8'd113;
		res = {h[15], 31'd0};
		if (h[14:10] == 5'd0) begin
			if (man != 10'd0) begin
				for (int k = 0; k < 10; k++) begin
					if (!man[9]) begin
						man = man << 1;
						e = e - 8'd1;
					end
				end
				// one more shift moves the leading one out
				man = man << 1;
				e = e - 8'd1;
				res = {h[15], e, man, 13'd0};
			end
		end else if (h[14:10] == 5'h1f) begin
			res = {h[15], 8'hff, man, 13'd0};
		end else begin
			res = {h[15], 8'({3'd0, h[14:10]} + 8'd112), man, 13'd0};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pixel_unpack_to_rgba_float_top.sv
// Pipeline: the pixel is converted between the input register and the result
// register. Throughput: one pixel per cycle while out_stall is low; input and
// result stages both advance whenever the next stage is free or being drained.
// Reset: arst_n asynchronous active low clears valids, format resets to RGBA8.
`default_nettype none
module pixel_unpack_to_rgba_float_top import pufp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire pixel_in_t in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output rgba_out_t      out_data
);

	logic [3:0]  fmt_q;
	logic        v_s1;
	pixel_in_t   d_s1;
	logic        adv_s1, adv_s2;
	rgba_out_t   res;
	logic [31:0] unorm_lut [256];

	assign adv_s2   = !out_valid || !out_stall;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// unorm8 to float32 constant table, folded at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_unorm_lut
		localparam logic [31:0] LUT_VAL = unorm8_f32(8'(g));
		assign unorm_lut[g] = LUT_VAL;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= FMT_RESET;
		else if (cfg_we) fmt_q <= cfg_wdata;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) out_valid <= v_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) d_s1 <= in_data;
		if (adv_s2 && v_s1) out_data <= res;
	end

	// format decode
	always_comb begin
		logic [31:0] w0, w1;
		w0 = d_s1.pixel_word0;
		w1 = d_s1.pixel_word1;
		res = '{32'd0, 32'd0, 32'd0, F32_ONE, 1'b1};
		unique case (fmt_q)
			FMT_R8: res.red_bits = unorm_lut[w0[7:0]];
			FMT_RG8: begin
				res.red_bits = unorm_lut[w0[7:0]];
				res.green_bits = unorm_lut[w0[15:8]];
			end
			FMT_RGB8: begin
				res.red_bits = unorm_lut[w0[7:0]];
				res.green_bits = unorm_lut[w0[15:8]];
				res.blue_bits = unorm_lut[w0[23:16]];
			end
			FMT_RGBA8, FMT_RGBA8SRGB: begin
				res.red_bits = unorm_lut[w0[7:0]];
				res.green_bits = unorm_lut[w0[15:8]];
				res.blue_bits = unorm_lut[w0[23:16]];
				res.alpha_bits = unorm_lut[w0[31:24]];
			end
			FMT_BGRA8, FMT_BGRA8SRGB: begin
				res.red_bits = unorm_lut[w0[23:16]];
				res.green_bits = unorm_lut[w0[15:8]];
				res.blue_bits = unorm_lut[w0[7:0]];
				res.alpha_bits = unorm_lut[w0[31:24]];
			end
			FMT_R16F: res.red_bits = half_f32(w0[15:0]);
			FMT_RG16F: begin
				res.red_bits = half_f32(w0[15:0]);
				res.green_bits = half_f32(w0[31:16]);
			end
			FMT_RGBA16F: begin
				res.red_bits = half_f32(w0[15:0]);
				res.green_bits = half_f32(w0[31:16]);
				res.blue_bits = half_f32(w1[15:0]);
				res.alpha_bits = half_f32(w1[31:16]);
			end
			FMT_R32F: res.red_bits = w0;
			FMT_RG32F: begin
				res.red_bits = w0;
				res.green_bits = w1;
			end
			FMT_RGBA32F: begin
				res.red_bits = w0;
				res.green_bits = w1;
				res.blue_bits = d_s1.pixel_word2;
				res.alpha_bits = d_s1.pixel_word3;
			end
			default: begin
				res.alpha_bits = 32'd0;
				res.format_ok = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/pufp_checker.sv
`default_nettype none
module pufp_checker import pufp_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire rgba_out_t out_data
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// unsupported format gives zero red and alpha channels
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.format_ok |-> out_data.red_bits == 32'd0 &&
		out_data.alpha_bits == 32'd0)
		else $error("unsupported format with nonzero channels");

	// input is never stalled while output side is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result stage");

	// accepted request passes the input register and shows up as a result unless stalled
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("result missing");

endmodule

bind pixel_unpack_to_rgba_float_top pufp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

>>> verif/tb_pixel_unpack_to_rgba_float_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_pixel_unpack_to_rgba_float_top;
	import pufp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LATENCY = 2;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	pixel_in_t  in_data;
	logic       out_valid;
	logic       out_stall;
	rgba_out_t  out_data;

	pixel_unpack_to_rgba_float_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor state
	logic [3:0] cur_format;
	rgba_out_t  expected_pixels[$];
	int         mismatch_count;
	int         pixels_sent;
	int         pixels_checked;
	int         idle_sender_pct;
	int         idle_receiver_pct;
	int         quiet_cycles;
	bit         formats_seen[16];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// nearest float32 to n/255, exact integer rounding
	function automatic logic [31:0] unorm_to_f32(input logic [7:0] n);
		logic [63:0] num;
		logic [63:0] q;
		logic [63:0] rem;
		int          sh;
		int          ex;
		num = 64'd0;
		q = 64'd0;
		if (n == 8'd0) return 32'd0;
		if (n == 8'd255) return F32_ONE;
		for (sh = 24; sh <= 31; sh++) begin
			num = 64'(n) << sh;
			q = num / 64'd255;
			if (q >= 64'h80_0000) break;
		end
		rem = num % 64'd255;
		if (2 * rem > 64'd255) q++;
		ex = 150 - sh;
		if (q >= 64'h100_0000) begin
			q = q >> 1;
			ex++;
		end
		return {1'b0, 8'(ex), q[22:0]};
	endfunction

	// half to float32 widening
	function automatic logic [31:0] half_to_f32(input logic [15:0] h);
		logic [31:0] sgn;
		logic [4:0]  hex;
		logic [10:0] man;
		int          ex;
		sgn = {h[15], 31'd0};
		hex = h[14:10];
		man = {1'b0, h[9:0]};
		if (hex == 5'd0) begin
			if (man == 11'd0) return sgn;
			ex = 1;
			while (!man[10]) begin
				man = man << 1;
				ex--;
			end
			return sgn | {1'b0, 8'(ex + 112), man[9:0], 13'd0};
		end
		if (hex == 5'h1f) return sgn | 32'h7f80_0000 | {19'd0, h[9:0], 3'd0} << 10;
		return sgn | {1'b0, 8'(hex + 112), h[9:0], 13'd0};
	endfunction

	function automatic rgba_out_t convert_pixel(input logic [3:0] fmt, input pixel_in_t px);
		rgba_out_t   res;
		logic [31:0] w0;
		w0 = px.pixel_word0;
		res.red_bits = 32'd0;
		res.green_bits = 32'd0;
		res.blue_bits = 32'd0;
		res.alpha_bits = F32_ONE;
		res.format_ok = 1'b1;
		case (fmt)
			FMT_R8: begin
				res.red_bits = unorm_to_f32(w0[7:0]);
			end
			FMT_RG8: begin
				res.red_bits = unorm_to_f32(w0[7:0]);
				res.green_bits = unorm_to_f32(w0[15:8]);
			end
			FMT_RGB8: begin
				res.red_bits = unorm_to_f32(w0[7:0]);
				res.green_bits = unorm_to_f32(w0[15:8]);
				res.blue_bits = unorm_to_f32(w0[23:16]);
			end
			FMT_RGBA8, FMT_RGBA8SRGB: begin
				res.red_bits = unorm_to_f32(w0[7:0]);
				res.green_bits = unorm_to_f32(w0[15:8]);
				res.blue_bits = unorm_to_f32(w0[23:16]);
				res.alpha_bits = unorm_to_f32(w0[31:24]);
			end
			FMT_BGRA8, FMT_BGRA8SRGB: begin
				res.red_bits = unorm_to_f32(w0[23:16]);
				res.green_bits = unorm_to_f32(w0[15:8]);
				res.blue_bits = unorm_to_f32(w0[7:0]);
				res.alpha_bits = unorm_to_f32(w0[31:24]);
			end
			FMT_R16F: begin
				res.red_bits = half_to_f32(w0[15:0]);
			end
			FMT_RG16F: begin
				res.red_bits = half_to_f32(w0[15:0]);
				res.green_bits = half_to_f32(w0[31:16]);
			end
			FMT_RGBA16F: begin
				res.red_bits = half_to_f32(w0[15:0]);
				res.green_bits = half_to_f32(w0[31:16]);
				res.blue_bits = half_to_f32(px.pixel_word1[15:0]);
				res.alpha_bits = half_to_f32(px.pixel_word1[31:16]);
			end
			FMT_R32F: begin
				res.red_bits = w0;
			end
			FMT_RG32F: begin
				res.red_bits = w0;
				res.green_bits = px.pixel_word1;
			end
			FMT_RGBA32F: begin
				res.red_bits = w0;
				res.green_bits = px.pixel_word1;
				res.blue_bits = px.pixel_word2;
				res.alpha_bits = px.pixel_word3;
			end
			default: begin
				res.alpha_bits = 32'd0;
				res.format_ok = 1'b0;
			end
		endcase
		return res;
	endfunction

	// send one request, with optional random idle cycles before it
	task automatic send_pixel(input pixel_in_t px);
		while ($urandom_range(99) < idle_sender_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		expected_pixels.push_back(convert_pixel(cur_format, px));
		pixels_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_idle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_format(input logic [3:0] fmt);
		drain_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= fmt;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_format = fmt;
		formats_seen[fmt] = 1'b1;
		@(posedge clk);
	endtask

	function automatic pixel_in_t random_pixel();
		pixel_in_t px;
		px.pixel_word0 = $urandom();
		px.pixel_word1 = $urandom();
		px.pixel_word2 = $urandom();
		px.pixel_word3 = $urandom();
		return px;
	endfunction

	// reset value of the format, then every format on edge patterns
	task automatic test_directed();
		pixel_in_t px;
		logic [31:0] edges[6];
		edges = '{32'h0000_0000, 32'hffff_ffff, 32'h7c00_fc00, 32'h0001_83ff,
			32'h7e01_0400, 32'h80ff_017f};
		px = '{32'h80ff_017f, 32'h0, 32'h0, 32'h0};
		send_pixel(px);
		for (int f = 0; f < 16; f++) begin
			write_format(4'(f));
			px = '{edges[f % 6], edges[(f + 1) % 6], edges[(f + 2) % 6], edges[(f + 3) % 6]};
			send_pixel(px);
		end
	endtask

	// every byte code through the RGBA8 unorm path
	task automatic test_unorm_codes();
		pixel_in_t px;
		write_format(FMT_RGBA8);
		for (int n = 0; n < 256; n += 4) begin
			px = random_pixel();
			px.pixel_word0 = {8'(n), 8'(n + 1), 8'(n + 2), 8'(n + 3)};
			send_pixel(px);
		end
	endtask

	task automatic test_random_phase(input int count, input int snd_pct, input int rcv_pct);
		idle_sender_pct = snd_pct;
		idle_receiver_pct = rcv_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) write_format(4'($urandom_range(15)));
			send_pixel(random_pixel());
		end
		drain_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		in_valid = 1'b0;
		in_data = '0;
		cur_format = FMT_RESET;
		idle_sender_pct = 0;
		idle_receiver_pct = 0;
		mismatch_count = 0;
		pixels_sent = 0;
		pixels_checked = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_unorm_codes();
		test_random_phase(400, 0, 0);
		test_random_phase(400, 47, 0);
		test_random_phase(400, 0, 47);
		test_random_phase(400, 6, 6);
		write_format(4'd15);
		write_format(FMT_R8);
		drain_idle();
		$display("Sent %0d pixels over all 16 format codes, checked %0d results,",
			pixels_sent, pixels_checked);
		$display("with sender gaps and receiver stalls in separate phases.");
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_receiver_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		rgba_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (want.red_bits !== out_data.red_bits ||
					want.green_bits !== out_data.green_bits ||
					want.blue_bits !== out_data.blue_bits ||
					want.alpha_bits !== out_data.alpha_bits ||
					want.format_ok !== out_data.format_ok) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp r=%h g=%h b=%h a=%h ok=%b got r=%h g=%h b=%h a=%h ok=%b",
							want.red_bits, want.green_bits, want.blue_bits,
							want.alpha_bits, want.format_ok, out_data.red_bits,
							out_data.green_bits, out_data.blue_bits,
							out_data.alpha_bits, out_data.format_ok);
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or result while results are outstanding
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| expected_pixels.size() == 0) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/pufp_pkg.sv
hw/rtl/pixel_unpack_to_rgba_float_top.sv
hw/rtl/pufp_checker.sv
verif/tb_pixel_unpack_to_rgba_float_top.sv
